[hw/rtl/pffa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Page frame allocator package
// Types, codes and constants shared by the allocator's controller, datapath,
// top level and checker.
// ----------------------------------------------------------------------------
package pffa_pkg;

  localparam int NumPages = 4096;
  localparam int PageW    = 12;
  localparam int CountW   = 13;
  localparam int FlagW    = 6;

  localparam logic [CountW-1:0] NumPagesC = CountW'(NumPages);
  localparam logic [CountW-1:0] LastPtrC  = CountW'(NumPages - 1);
  localparam logic [PageW-1:0]  LastPageC = PageW'(NumPages - 1);

  typedef enum logic [1:0] {
    OP_ADD_RANGE = 2'd0,
    OP_ALLOC     = 2'd1,
    OP_FREE      = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_BAD_RANGE   = 3'd2,
    ST_NOT_ALLOC   = 3'd3,
    ST_OVERLAP     = 3'd4
  } status_e;

  localparam logic [2:0] KIND_UNUSED    = 3'd0;
  localparam logic [2:0] KIND_ALLOCATED = 3'd1;
  localparam logic [2:0] KIND_AVAILABLE = 3'd2;
  localparam logic [2:0] KIND_HARDWARE  = 3'd3;
  localparam logic [2:0] KIND_KERNEL    = 3'd4;
  localparam logic [2:0] KIND_HEAP      = 3'd5;

  localparam logic [FlagW-1:0] FLAG_AVAIL  = 6'h01;
  localparam logic [FlagW-1:0] FLAG_KERNEL = 6'h02;
  localparam logic [FlagW-1:0] FLAG_HW     = 6'h04;
  localparam logic [FlagW-1:0] FLAG_ALLOC  = 6'h08;
  localparam logic [FlagW-1:0] FLAG_UNUSED = 6'h10;
  localparam logic [FlagW-1:0] FLAG_HEAP   = 6'h20;

  typedef struct packed {
    op_e                operation;
    logic [PageW-1:0]   range_start;
    logic [CountW-1:0]  range_end;
    logic [2:0]         page_kind;
    logic [PageW-1:0]   freed_page;
  } in_word_t;

  typedef struct packed {
    status_e            status;
    logic [PageW-1:0]   granted_page;
    logic [CountW-1:0]  free_total;
  } out_word_t;

  typedef enum logic [8:0] {
    S_CLEAR     = 9'b000000001,
    S_IDLE      = 9'b000000010,
    S_DECODE    = 9'b000000100,
    S_ADD_SCAN  = 9'b000001000,
    S_ADD_WRITE = 9'b000010000,
    S_ALLOC_QRD = 9'b000100000,
    S_ALLOC_FRD = 9'b001000000,
    S_FREE_FRD  = 9'b010000000,
    S_RESULT    = 9'b100000000
  } state_e;

  typedef struct packed {
    logic    load_item;
    logic    clear_step;
    logic    ptr_rewind;
    logic    scan_step;
    logic    write_step;
    logic    q_read;
    logic    pop;
    logic    f_read_alloc;
    logic    alloc_commit;
    logic    f_read_free;
    logic    free_commit;
    logic    res_set;
    status_e res_status;
    logic    res_grant;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic range_bad;
    logic add_overflow;
    logic free_bad;
    logic count_zero;
    logic count_full;
    logic scan_hit;
    logic scan_done;
    logic write_done;
    logic clear_done;
    logic flag_alloc;
    logic out_ready;
  } sts_t;

  function automatic logic [FlagW-1:0] kind_flag(input logic [2:0] kind);
    logic [FlagW-1:0] f;
    case (kind)
      KIND_UNUSED:    f = FLAG_UNUSED;
      KIND_ALLOCATED: f = FLAG_ALLOC;
      KIND_AVAILABLE: f = FLAG_AVAIL;
      KIND_HARDWARE:  f = FLAG_HW;
      KIND_KERNEL:    f = FLAG_KERNEL;
      KIND_HEAP:      f = FLAG_HEAP;
      default:        f = '0;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/pffa_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pffa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hw/rtl/pffa_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Page frame allocator controller
// Sequences the clearing pass, the range walk, allocate and free.
// ----------------------------------------------------------------------------
module pffa_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire pffa_pkg::sts_t  sts_i,
  output pffa_pkg::cmd_t       cmd_o
);

  pffa_pkg::state_e state_q, state_d;
  pffa_pkg::cmd_t   cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      pffa_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts_i.clear_done) begin
          state_d = pffa_pkg::S_IDLE;
        end
      end
      pffa_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd.load_item = 1'b1;
          state_d       = pffa_pkg::S_DECODE;
        end
      end
      pffa_pkg::S_DECODE: begin
        unique case (sts_i.op)
          pffa_pkg::OP_ADD_RANGE: begin
            if (sts_i.range_bad) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = pffa_pkg::ST_BAD_RANGE;
              state_d        = pffa_pkg::S_RESULT;
            end else if (sts_i.add_overflow) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = pffa_pkg::ST_OVERLAP;
              state_d        = pffa_pkg::S_RESULT;
            end else begin
              state_d = pffa_pkg::S_ADD_SCAN;
            end
          end
          pffa_pkg::OP_ALLOC: begin
            if (sts_i.count_zero) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = pffa_pkg::ST_EMPTY;
              state_d        = pffa_pkg::S_RESULT;
            end else begin
              cmd.q_read = 1'b1;
              state_d    = pffa_pkg::S_ALLOC_QRD;
            end
          end
          pffa_pkg::OP_FREE: begin
            if (sts_i.free_bad) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = pffa_pkg::ST_BAD_RANGE;
              state_d        = pffa_pkg::S_RESULT;
            end else begin
              cmd.f_read_free = 1'b1;
              state_d         = pffa_pkg::S_FREE_FRD;
            end
          end
          default: begin
            cmd.res_set    = 1'b1;
            cmd.res_status = pffa_pkg::ST_OK;
            state_d        = pffa_pkg::S_RESULT;
          end
        endcase
      end
      pffa_pkg::S_ADD_SCAN: begin
        if (sts_i.scan_hit) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = pffa_pkg::ST_OVERLAP;
          state_d        = pffa_pkg::S_RESULT;
        end else if (sts_i.scan_done) begin
          cmd.ptr_rewind = 1'b1;
          state_d        = pffa_pkg::S_ADD_WRITE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      pffa_pkg::S_ADD_WRITE: begin
        if (sts_i.write_done) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = pffa_pkg::ST_OK;
          state_d        = pffa_pkg::S_RESULT;
        end else begin
          cmd.write_step = 1'b1;
        end
      end
      pffa_pkg::S_ALLOC_QRD: begin
        cmd.f_read_alloc = 1'b1;
        cmd.pop          = 1'b1;
        state_d          = pffa_pkg::S_ALLOC_FRD;
      end
      pffa_pkg::S_ALLOC_FRD: begin
        cmd.res_set = 1'b1;
        state_d     = pffa_pkg::S_RESULT;
        if (sts_i.flag_alloc) begin
          cmd.res_status = pffa_pkg::ST_OVERLAP;
        end else begin
          cmd.alloc_commit = 1'b1;
          cmd.res_status   = pffa_pkg::ST_OK;
          cmd.res_grant    = 1'b1;
        end
      end
      pffa_pkg::S_FREE_FRD: begin
        cmd.res_set = 1'b1;
        state_d     = pffa_pkg::S_RESULT;
        if (!sts_i.flag_alloc) begin
          cmd.res_status = pffa_pkg::ST_NOT_ALLOC;
        end else if (sts_i.count_full) begin
          cmd.res_status = pffa_pkg::ST_OVERLAP;
        end else begin
          cmd.free_commit = 1'b1;
          cmd.res_status  = pffa_pkg::ST_OK;
        end
      end
      pffa_pkg::S_RESULT: begin
        if (sts_i.out_ready) begin
          cmd.out_load = 1'b1;
          state_d      = pffa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pffa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pffa_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o      = cmd;
  assign in_stall_o = (state_q != pffa_pkg::S_IDLE);

endmodule
`default_nettype wire

[hw/rtl/pffa_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Page frame allocator datapath
// Flag memory, free list memory, queue pointers, page walker and the result
// register.
// ----------------------------------------------------------------------------
module pffa_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pffa_pkg::in_word_t  in_word_i,
  input  wire pffa_pkg::cmd_t      cmd_i,
  output pffa_pkg::sts_t           sts_o,
  output logic                     out_valid_o,
  output pffa_pkg::out_word_t      out_word_o,
  input  wire logic                out_stall_i
);

  localparam int PageW  = pffa_pkg::PageW;
  localparam int CountW = pffa_pkg::CountW;
  localparam int FlagW  = pffa_pkg::FlagW;

  pffa_pkg::in_word_t  item_q;
  logic [CountW-1:0]   ptr_q, ptr_d;
  logic [PageW-1:0]    head_q, head_d;
  logic [PageW-1:0]    tail_q, tail_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [PageW-1:0]    page_q;
  logic                pend_q, pend_d;
  pffa_pkg::status_e   res_status_q;
  logic                res_grant_q;
  logic                out_valid_q, out_valid_d;
  pffa_pkg::out_word_t out_word_q;

  logic                f_we, f_re;
  logic [PageW-1:0]    f_waddr, f_raddr;
  logic [FlagW-1:0]    f_wdata, f_rdata;
  logic                q_we;
  logic [PageW-1:0]    q_wdata, q_rdata;

  logic                ptr_lt_end;
  logic [FlagW-1:0]    kind_f;
  logic                is_avail;
  logic [CountW-1:0]   range_len;
  logic [CountW:0]     count_sum;
  logic                out_ready;

  assign ptr_lt_end = (ptr_q < item_q.range_end);
  assign kind_f     = pffa_pkg::kind_flag(item_q.page_kind);
  assign is_avail   = (kind_f == pffa_pkg::FLAG_AVAIL);
  assign range_len  = item_q.range_end - {1'b0, item_q.range_start};
  assign count_sum  = {1'b0, count_q} + {1'b0, range_len};
  assign out_ready  = !out_valid_q || !out_stall_i;

  always_comb begin
    f_we    = 1'b0;
    f_waddr = ptr_q[PageW-1:0];
    f_wdata = '0;
    if (cmd_i.clear_step) begin
      f_we = 1'b1;
    end else if (cmd_i.write_step && ptr_lt_end) begin
      f_we    = 1'b1;
      f_wdata = kind_f;
    end else if (cmd_i.alloc_commit) begin
      f_we    = 1'b1;
      f_waddr = page_q;
      f_wdata = f_rdata | pffa_pkg::FLAG_ALLOC;
    end else if (cmd_i.free_commit) begin
      f_we    = 1'b1;
      f_waddr = item_q.freed_page;
      f_wdata = f_rdata & ~pffa_pkg::FLAG_ALLOC;
    end
  end

  always_comb begin
    f_re    = 1'b0;
    f_raddr = ptr_q[PageW-1:0];
    if (cmd_i.scan_step && ptr_lt_end) begin
      f_re = 1'b1;
    end else if (cmd_i.f_read_alloc) begin
      f_re    = 1'b1;
      f_raddr = q_rdata;
    end else if (cmd_i.f_read_free) begin
      f_re    = 1'b1;
      f_raddr = item_q.freed_page;
    end
  end

  always_comb begin
    q_we    = 1'b0;
    q_wdata = ptr_q[PageW-1:0];
    if (cmd_i.write_step && ptr_lt_end && is_avail) begin
      q_we = 1'b1;
    end else if (cmd_i.free_commit) begin
      q_we    = 1'b1;
      q_wdata = item_q.freed_page;
    end
  end

  pffa_ram #(
    .Width (FlagW),
    .Depth (pffa_pkg::NumPages)
  ) u_flags_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .re_i    (f_re),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  pffa_ram #(
    .Width (PageW),
    .Depth (pffa_pkg::NumPages)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (tail_q),
    .wdata_i (q_wdata),
    .re_i    (cmd_i.q_read),
    .raddr_i (head_q),
    .rdata_o (q_rdata)
  );

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.load_item) begin
      ptr_d = {1'b0, in_word_i.range_start};
    end else if (cmd_i.ptr_rewind) begin
      ptr_d = {1'b0, item_q.range_start};
    end else if (cmd_i.clear_step || ((cmd_i.scan_step || cmd_i.write_step) && ptr_lt_end)) begin
      ptr_d = ptr_q + 1'b1;
    end
  end

  assign pend_d = cmd_i.scan_step && ptr_lt_end;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (q_we) begin
      tail_d  = (tail_q == pffa_pkg::LastPageC) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end else if (cmd_i.pop) begin
      head_d  = (head_q == pffa_pkg::LastPageC) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ptr_q       <= ptr_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_word_i;
    end
    if (cmd_i.f_read_alloc) begin
      page_q <= q_rdata;
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_grant_q  <= cmd_i.res_grant;
    end
    if (cmd_i.out_load) begin
      out_word_q.status       <= res_status_q;
      out_word_q.granted_page <= res_grant_q ? page_q : '0;
      out_word_q.free_total   <= count_q;
    end
  end

  always_comb begin
    sts_o              = '0;
    sts_o.op           = item_q.operation;
    sts_o.range_bad    = (item_q.page_kind > pffa_pkg::KIND_HEAP) ||
                         ({1'b0, item_q.range_start} >= item_q.range_end) ||
                         (item_q.range_end > pffa_pkg::NumPagesC);
    sts_o.add_overflow = is_avail && (count_sum > {1'b0, pffa_pkg::NumPagesC});
    sts_o.free_bad     = ({1'b0, item_q.freed_page} >= pffa_pkg::NumPagesC);
    sts_o.count_zero   = (count_q == '0);
    sts_o.count_full   = (count_q >= pffa_pkg::NumPagesC);
    sts_o.scan_hit     = pend_q && (f_rdata != '0);
    sts_o.scan_done    = !ptr_lt_end && !pend_q;
    sts_o.write_done   = !ptr_lt_end;
    sts_o.clear_done   = (ptr_q == pffa_pkg::LastPtrC);
    sts_o.flag_alloc   = ((f_rdata & pffa_pkg::FLAG_ALLOC) != '0);
    sts_o.out_ready    = out_ready;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
`default_nettype wire

[hw/rtl/page_frame_free_list_allocator_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Page frame free list allocator
// Keeps a flag word per page and a FIFO free list of page numbers; adds page
// ranges, allocates from the front of the list and frees to its back.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the flag memory, one page
// per cycle, and stalls its input until it is done. It then works on one word
// at a time, and all timing is set by the controller's sequence around the
// single-port reads of the flag and free list memories, whose read data is
// registered. An allocate reads the front of the free list and then that
// page's flags, a free reads the freed page's flags, and a word rejected by
// its decode checks, or ignored, goes straight to its result. An accepted
// add-range first reads the flags of the pages in the range, then writes them
// and queues the available pages. The next word can be taken in the cycle
// after the result is loaded into the output register, so a waiting result
// does not hold up the following word's work until that word's own result
// is ready.
module page_frame_free_list_allocator_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire pffa_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output pffa_pkg::out_word_t      out_word_o
);

  pffa_pkg::cmd_t cmd;
  pffa_pkg::sts_t sts;

  pffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pffa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i)
  );

endmodule
`default_nettype wire

[hw/rtl/pffa_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Page frame allocator checker
// Port-level properties of the allocator, bound to its top level.
// ----------------------------------------------------------------------------
module pffa_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_i,
  input wire logic                out_valid_i,
  input wire logic                out_stall_i,
  input wire pffa_pkg::out_word_t out_word_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_word_i))
  else $error("Stalled result word was dropped or changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_word_i.free_total <= pffa_pkg::NumPagesC)
  else $error("Free page total exceeds the number of pages.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.status != pffa_pkg::ST_OK |-> out_word_i.granted_page == '0)
  else $error("Failed operation reports a granted page.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.status == pffa_pkg::ST_EMPTY |-> out_word_i.free_total == '0)
  else $error("Empty free list reported with pages on it.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
  else $error("Second word accepted while the first is in progress.");

endmodule

bind page_frame_free_list_allocator_core pffa_checker u_pffa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_i  (out_word_o)
);
`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Page frame free list allocator testbench
// Drives add-range, allocate and free words through the valid/stall input
// channel and checks every result word against the directed table or a
// behavioral model of the page flags and the FIFO free list. A short table of
// directed words covers the error codes, the field extremes, the overflow of
// the free list, a stale entry at the front of the list and a full list. Random
// traffic follows: mostly allocations and frees of pages that are really held,
// with some malformed words mixed in. Both channels idle at random, but for
// the last third of the random traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PageW       = pffa_pkg::PageW;
  localparam int CountW      = pffa_pkg::CountW;
  localparam int FlagW       = pffa_pkg::FlagW;
  localparam int NumPages    = pffa_pkg::NumPages;
  localparam int PlanLen     = 27;
  localparam int RandomWords = 1050;
  localparam int QuietLimit  = 30000;
  localparam int EndSettle   = 16;
  localparam logic [2:0] KindBogus = 3'd7;

  typedef struct packed {
    pffa_pkg::in_word_t  word;
    logic                known;
    pffa_pkg::out_word_t want;
  } probe_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  pffa_pkg::in_word_t  in_word   = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  pffa_pkg::out_word_t out_word;

  int send_idle_pct = 16;
  int stall_pct     = 65;
  int fault_count   = 0;
  int quiet_cycles  = 0;

  logic [FlagW-1:0]  frame_flags [NumPages];
  logic [PageW-1:0]  frame_fifo  [NumPages];
  logic [PageW-1:0]  fifo_rd;
  logic [PageW-1:0]  fifo_wr;
  logic [CountW-1:0] fifo_count;

  pffa_pkg::out_word_t pending_answers[$];
  logic [PageW-1:0]    held_pages[$];
  pffa_pkg::out_word_t head_answer;
  probe_t              plan [PlanLen];

  page_frame_free_list_allocator_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always #2 clk = ~clk;

  function automatic probe_t row(input pffa_pkg::op_e op, input int first, input int past,
                                 input logic [2:0] kind, input int page,
                                 input logic known, input pffa_pkg::status_e st,
                                 input int grant, input int total);
    probe_t r;
    r = '0;
    r.word.operation         = op;
    r.word.range_start       = PageW'(first);
    r.word.range_end         = CountW'(past);
    r.word.page_kind         = kind;
    r.word.freed_page        = PageW'(page);
    r.known                  = known;
    r.want.status            = st;
    r.want.granted_page      = PageW'(grant);
    r.want.free_total        = CountW'(total);
    return r;
  endfunction

  function automatic pffa_pkg::out_word_t allocator_answer(input pffa_pkg::in_word_t w);
    pffa_pkg::out_word_t ans;
    logic [FlagW-1:0]    mark;
    logic [PageW-1:0]    pg;
    logic                described;
    ans = '0;
    ans.status = pffa_pkg::ST_OK;
    case (w.operation)
      pffa_pkg::OP_ADD_RANGE: begin
        case (w.page_kind)
          pffa_pkg::KIND_UNUSED:    mark = pffa_pkg::FLAG_UNUSED;
          pffa_pkg::KIND_ALLOCATED: mark = pffa_pkg::FLAG_ALLOC;
          pffa_pkg::KIND_AVAILABLE: mark = pffa_pkg::FLAG_AVAIL;
          pffa_pkg::KIND_HARDWARE:  mark = pffa_pkg::FLAG_HW;
          pffa_pkg::KIND_KERNEL:    mark = pffa_pkg::FLAG_KERNEL;
          pffa_pkg::KIND_HEAP:      mark = pffa_pkg::FLAG_HEAP;
          default:                  mark = '0;
        endcase
        if (mark == '0 || CountW'(w.range_start) >= w.range_end ||
            w.range_end > pffa_pkg::NumPagesC) begin
          ans.status = pffa_pkg::ST_BAD_RANGE;
        end else begin
          described = 1'b0;
          for (int p = int'(w.range_start); p < int'(w.range_end); p++) begin
            if (frame_flags[p] != '0) described = 1'b1;
          end
          if (described || (mark == pffa_pkg::FLAG_AVAIL &&
                            int'(fifo_count) + int'(w.range_end)
                            - int'(w.range_start) > NumPages)) begin
            ans.status = pffa_pkg::ST_OVERLAP;
          end else begin
            for (int p = int'(w.range_start); p < int'(w.range_end); p++) begin
              frame_flags[p] = mark;
              if (mark == pffa_pkg::FLAG_AVAIL) begin
                frame_fifo[fifo_wr] = PageW'(p);
                fifo_wr++;
                fifo_count++;
              end
            end
          end
        end
      end
      pffa_pkg::OP_ALLOC: begin
        if (fifo_count == '0) begin
          ans.status = pffa_pkg::ST_EMPTY;
        end else begin
          pg = frame_fifo[fifo_rd];
          fifo_rd++;
          fifo_count--;
          if ((frame_flags[pg] & pffa_pkg::FLAG_ALLOC) != '0) begin
            ans.status = pffa_pkg::ST_OVERLAP;
          end else begin
            frame_flags[pg] = frame_flags[pg] | pffa_pkg::FLAG_ALLOC;
            ans.granted_page = pg;
          end
        end
      end
      pffa_pkg::OP_FREE: begin
        if ((frame_flags[w.freed_page] & pffa_pkg::FLAG_ALLOC) == '0) begin
          ans.status = pffa_pkg::ST_NOT_ALLOC;
        end else if (fifo_count >= pffa_pkg::NumPagesC) begin
          ans.status = pffa_pkg::ST_OVERLAP;
        end else begin
          frame_flags[w.freed_page] = frame_flags[w.freed_page] & ~pffa_pkg::FLAG_ALLOC;
          frame_fifo[fifo_wr] = w.freed_page;
          fifo_wr++;
          fifo_count++;
        end
      end
      default: ;
    endcase
    ans.free_total = fifo_count;
    return ans;
  endfunction

  task automatic send_word(input pffa_pkg::in_word_t w, input logic known,
                           input pffa_pkg::out_word_t want);
    pffa_pkg::out_word_t guess;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    guess = allocator_answer(w);
    pending_answers.push_back(known ? want : guess);
    if (w.operation == pffa_pkg::OP_ALLOC && guess.status == pffa_pkg::ST_OK) begin
      held_pages.push_back(guess.granted_page);
    end
    if (w.operation == pffa_pkg::OP_FREE && guess.status == pffa_pkg::ST_OK) begin
      for (int i = 0; i < held_pages.size(); i++) begin
        if (held_pages[i] == w.freed_page) begin
          held_pages.delete(i);
          break;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    if (out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result word: status %0d, granted_page %0d, free_total %0d",
               out_word.status, out_word.granted_page, out_word.free_total);
        fault_count++;
      end else begin
        head_answer = pending_answers.pop_front();
        if (out_word.status !== head_answer.status) begin
          $error("status: expected %0d, got %0d", head_answer.status, out_word.status);
          fault_count++;
        end
        if (out_word.granted_page !== head_answer.granted_page) begin
          $error("granted_page: expected %0d, got %0d", head_answer.granted_page,
                 out_word.granted_page);
          fault_count++;
        end
        if (out_word.free_total !== head_answer.free_total) begin
          $error("free_total: expected %0d, got %0d", head_answer.free_total,
                 out_word.free_total);
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk);
    $display("[page_frame_free_list_allocator_core] ERROR");
    $finish;
  end

  initial begin
    pffa_pkg::in_word_t w;
    logic [63:0]        noise;
    int                 pick;
    foreach (frame_flags[i]) frame_flags[i] = '0;
    fifo_rd    = '0;
    fifo_wr    = '0;
    fifo_count = '0;

    // Pages 0 to 4 are described as allocated and freed again, so they sit on
    // the list with clear flags. That lets one add overflow the list, and the
    // later fill queues them twice, which sets up the full list and the stale
    // front entry.
    plan = '{
      row(pffa_pkg::OP_ALLOC, 0, 0, pffa_pkg::KIND_UNUSED, 0,
          1, pffa_pkg::ST_EMPTY, 0, 0),
      row(pffa_pkg::OP_FREE, 0, 0, pffa_pkg::KIND_UNUSED, 4095,
          1, pffa_pkg::ST_NOT_ALLOC, 0, 0),
      row(pffa_pkg::OP_ADD_RANGE, 4095, 4095, pffa_pkg::KIND_AVAILABLE, 0,
          1, pffa_pkg::ST_BAD_RANGE, 0, 0),
      row(pffa_pkg::OP_ADD_RANGE, 0, 8191, pffa_pkg::KIND_AVAILABLE, 0,
          1, pffa_pkg::ST_BAD_RANGE, 0, 0),
      row(pffa_pkg::OP_ADD_RANGE, 0, 1, KindBogus, 0,
          1, pffa_pkg::ST_BAD_RANGE, 0, 0),
      row(pffa_pkg::OP_NONE, 4095, 8191, KindBogus, 4095,
          1, pffa_pkg::ST_OK, 0, 0),
      row(pffa_pkg::OP_ADD_RANGE, 0, 5, pffa_pkg::KIND_ALLOCATED, 0,
          1, pffa_pkg::ST_OK, 0, 0),
      row(pffa_pkg::OP_FREE, 0, 0, pffa_pkg::KIND_UNUSED, 0,
          0, pffa_pkg::ST_OK, 0, 0),
      row(pffa_pkg::OP_FREE, 0, 0, pffa_pkg::KIND_UNUSED, 1,
          0, pffa_pkg::ST_OK, 0, 0),
      row(pffa_pkg::OP_FREE, 0, 0, pffa_pkg::KIND_UNUSED, 2,
          0, pffa_pkg::ST_OK, 0, 0),
      row(pffa_pkg::OP_FREE, 0, 0, pffa_pkg::KIND_UNUSED, 3,
          0, pffa_pkg::ST_OK, 0, 0),
      row(pffa_pkg::OP_FREE, 0, 0, pffa_pkg::KIND_UNUSED, 4,
          0, pffa_pkg::ST_OK, 0, 0),
      row(pffa_pkg::OP_ADD_RANGE, 0, 4096, pffa_pkg::KIND_AVAILABLE, 0,
          1, pffa_pkg::ST_OVERLAP, 0, 5),
      row(pffa_pkg::OP_ADD_RANGE, 4091, 4092, pffa_pkg::KIND_ALLOCATED, 0,
          0, pffa_pkg::ST_OK, 0, 0),
      row(pffa_pkg::OP_ADD_RANGE, 4092, 4093, pffa_pkg::KIND_UNUSED, 0,
          0, pffa_pkg::ST_OK, 0, 0),
      row(pffa_pkg::OP_ADD_RANGE, 4093, 4094, pffa_pkg::KIND_HARDWARE, 0,
          0, pffa_pkg::ST_OK, 0, 0),
      row(pffa_pkg::OP_ADD_RANGE, 4094, 4095, pffa_pkg::KIND_KERNEL, 0,
          0, pffa_pkg::ST_OK, 0, 0),
      row(pffa_pkg::OP_ADD_RANGE, 4095, 4096, pffa_pkg::KIND_HEAP, 0,
          0, pffa_pkg::ST_OK, 0, 0),
      row(pffa_pkg::OP_ADD_RANGE, 0, 4091, pffa_pkg::KIND_AVAILABLE, 0,
          0, pffa_pkg::ST_OK, 0, 0),
      row(pffa_pkg::OP_ALLOC, 0, 0, pffa_pkg::KIND_UNUSED, 0,
          0, pffa_pkg::ST_OK, 0, 0),
      row(pffa_pkg::OP_FREE, 0, 0, pffa_pkg::KIND_UNUSED, 4091,
          0, pffa_pkg::ST_OK, 0, 0),
      row(pffa_pkg::OP_FREE, 0, 0, pffa_pkg::KIND_UNUSED, 0,
          1, pffa_pkg::ST_OVERLAP, 0, 4096),
      row(pffa_pkg::OP_ALLOC, 0, 0, pffa_pkg::KIND_UNUSED, 0,
          0, pffa_pkg::ST_OK, 0, 0),
      row(pffa_pkg::OP_ALLOC, 0, 0, pffa_pkg::KIND_UNUSED, 0,
          0, pffa_pkg::ST_OK, 0, 0),
      row(pffa_pkg::OP_ALLOC, 0, 0, pffa_pkg::KIND_UNUSED, 0,
          0, pffa_pkg::ST_OK, 0, 0),
      row(pffa_pkg::OP_ALLOC, 0, 0, pffa_pkg::KIND_UNUSED, 0,
          0, pffa_pkg::ST_OK, 0, 0),
      row(pffa_pkg::OP_ALLOC, 0, 0, pffa_pkg::KIND_UNUSED, 0,
          0, pffa_pkg::ST_OK, 0, 0)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PlanLen; i++) begin
      send_word(plan[i].word, plan[i].known, plan[i].want);
    end

    for (int n = 0; n < RandomWords; n++) begin
      if (n == RandomWords / 3) begin
        send_idle_pct = 65;
        stall_pct     = 16;
      end
      if (n == 2 * RandomWords / 3) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      noise = {$urandom(), $urandom()};
      w     = noise[$bits(pffa_pkg::in_word_t)-1:0];
      pick  = $urandom_range(99);
      if (pick < 40) begin
        w.operation = pffa_pkg::OP_ALLOC;
      end else if (pick < 75) begin
        w.operation = pffa_pkg::OP_ALLOC;
        if (held_pages.size() != 0) begin
          w.operation  = pffa_pkg::OP_FREE;
          w.freed_page = held_pages[$urandom_range(held_pages.size() - 1)];
        end
      end else if (pick < 85) begin
        w.operation = pffa_pkg::OP_FREE;
      end else if (pick < 95) begin
        w.operation = pffa_pkg::OP_ADD_RANGE;
        if ($urandom_range(1) == 1) begin
          w.range_end = CountW'(w.range_start) + CountW'($urandom_range(8, 1));
        end
      end else begin
        w.operation = pffa_pkg::OP_NONE;
      end
      send_word(w, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (EndSettle) @(posedge clk);
    if (fault_count == 0) begin
      $display("[page_frame_free_list_allocator_core] OK");
    end else begin
      $display("[page_frame_free_list_allocator_core] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/pffa_pkg.sv
hw/rtl/pffa_ram.sv
hw/rtl/pffa_ctrl.sv
hw/rtl/pffa_dp.sv
hw/rtl/page_frame_free_list_allocator_core.sv
hw/rtl/pffa_checker.sv
sim/testbench.sv
